// File: hdl/thermistor_beta_temperature_defines.svh
// Assertion macros shared by the thermistor temperature design
`ifndef THERMISTOR_BETA_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_BETA_TEMPERATURE_DEFINES_SVH

// Same-cycle implication, clocked on clk and quiet during reset
`define TBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and quiet during reset
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tbt_pkg.sv
// Types and constants of the thermistor temperature pipeline
package tbt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUPPLY_W = 16;
    localparam int OHMS_W   = 20;
    localparam int BETA_W   = 16;
    localparam int TEMP_W   = 16;
    localparam int PROD_W   = 36;   // series * (supply - v) and v * nominal
    localparam int EXP_W    = 6;    // integer part of log2 of a PROD_W value
    localparam int INV_FRAC = 48;
    localparam int LN2_W    = 25;
    localparam int TQ_W     = 17;   // quotient bits kept for the temperature

    localparam logic [LN2_W-1:0] LN2_Q25 = 25'd23258160;
    localparam logic [63:0] ONE_Q48     = 64'd1 << INV_FRAC;
    localparam logic [63:0] T0INV_Q48   = (ONE_Q48 * 64'd20 + 64'd2981) / 64'd5963;
    localparam logic [63:0] HUNDRED_Q48 = ONE_Q48 * 64'd100;
    localparam logic [OHMS_W-1:0] RES_MAX = 20'hFFFFF;
    localparam logic signed [TEMP_W-1:0] KELVIN_OFFSET = 16'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd32768;

    typedef enum logic [7:0] {
        REG_SUPPLY  = 8'd0,
        REG_SERIES  = 8'd1,
        REG_NOMINAL = 8'd2,
        REG_BETA    = 8'd3
    } cfg_reg_t;

    // Carried alongside the resistance division
    typedef struct packed {
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] b;
        logic              fault;
        logic              sat;
    } res_side_t;

    // Carried alongside the log and the beta division
    typedef struct packed {
        logic [OHMS_W-1:0] res;
        logic              fault;
        logic              degen;
        logic              neg;
    } ln_side_t;

    // Carried alongside the reciprocal division
    typedef struct packed {
        logic [OHMS_W-1:0] res;
        logic              fault;
        logic              degen;
        logic              inv_neg;
        logic              inv_zero;
        logic              sat;
    } inv_side_t;

endpackage

// File: hdl/thermistor_beta_temperature.sv
// Top level: NTC thermistor resistance and temperature from a divider voltage
//
//   channel   dir  beat content
//   s_axis    in   tdata[15:0] sample_mv
//   m_axis    out  tdata[19:0] resistance_ohms, tdata[35:20] temperature_centi; tuser fault
//   cfg       in   cfg_index register, cfg_data value (always ready)
//
// One sample enters per cycle unless a held result stalls the pipeline; the depth is set by the
// bit-per-stage dividers (20, 55 and 17 stages) and one squaring stage per log fraction bit.
// Reset clears the valid bits and loads the register defaults.
// A held result stalls the whole pipeline; s_tready drops only while m_tvalid waits.
`include "thermistor_beta_temperature_defines.svh"
module thermistor_beta_temperature #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // sample_mv
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // resistance_ohms, temperature_centi, pad
    output logic [0:0]                    m_tuser,   // fault
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_index,
    input  logic [tbt_pkg::OHMS_W-1:0]    cfg_data
);
    import tbt_pkg::*;

    localparam int L       = LOG_FRAC_BITS;
    localparam int LW      = EXP_W + L;              // log2 value
    localparam int PRD_W   = LW + LN2_W;             // d * ln2
    localparam int TNUM_W  = LW + INV_FRAC - L + 1;  // beta division numerator
    localparam int MAG_W   = TNUM_W + 1;             // |reciprocal temperature|
    localparam int NUM_T_W = MAG_W + 1;              // reciprocal division numerator
    localparam int RNUM_W  = PROD_W + 1;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    // Configuration registers
    logic [SUPPLY_W-1:0] supply_reg;
    logic [OHMS_W-1:0]   series_reg;
    logic [OHMS_W-1:0]   nominal_reg;
    logic [BETA_W-1:0]   beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg  <= 16'd3300;
            series_reg  <= 20'd10000;
            nominal_reg <= 20'd10000;
            beta_reg    <= 16'd3950;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SUPPLY:  supply_reg  <= cfg_data[SUPPLY_W-1:0];
                REG_SERIES:  series_reg  <= cfg_data;
                REG_NOMINAL: nominal_reg <= cfg_data;
                REG_BETA:    beta_reg    <= cfg_data[BETA_W-1:0];
                default:     ;
            endcase
        end
    end

    // Stage 1: range check and the two products
    logic [SAMPLE_W-1:0] v_in;
    logic [SAMPLE_W-1:0] s1_v_reg;
    logic [PROD_W-1:0]   s1_a_reg;
    logic [PROD_W-1:0]   s1_b_reg;
    logic                s1_fault_reg;
    logic                s1_valid_reg;
    logic [PROD_W-1:0]   a_next;
    logic [PROD_W-1:0]   b_next;

    assign v_in   = s_tdata[SAMPLE_W-1:0];
    assign a_next = PROD_W'(series_reg) * PROD_W'(supply_reg - v_in);
    assign b_next = PROD_W'(v_in) * PROD_W'(nominal_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_v_reg     <= v_in;
            s1_a_reg     <= a_next;
            s1_b_reg     <= b_next;
            s1_fault_reg <= (v_in == '0) || (v_in >= supply_reg);
        end
    end

    // Resistance division, saturation decided up front
    logic [RNUM_W-1:0]   rnum;
    logic                rsat;
    logic [RNUM_W-1:0]   rdiv_num;
    logic [SAMPLE_W-1:0] rdiv_den;
    res_side_t           rside_in;
    res_side_t           rside_out;
    logic                rdiv_valid;
    logic [OHMS_W-1:0]   rquo;

    assign rnum     = RNUM_W'(s1_a_reg) + RNUM_W'(s1_v_reg >> 1);
    assign rsat     = rnum >= (RNUM_W'(s1_v_reg) << OHMS_W);
    assign rdiv_num = (s1_fault_reg || rsat) ? '0 : rnum;
    assign rdiv_den = s1_fault_reg ? SAMPLE_W'(1) : s1_v_reg;
    assign rside_in = '{a: s1_a_reg, b: s1_b_reg, fault: s1_fault_reg, sat: rsat};

    tbt_div #(
        .NW (RNUM_W),
        .DW (SAMPLE_W),
        .QW (OHMS_W),
        .SW ($bits(res_side_t))
    ) u_res_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .num       (rdiv_num),
        .den       (rdiv_den),
        .side_in   (rside_in),
        .out_valid (rdiv_valid),
        .quo       (rquo),
        .side_out  (rside_out)
    );

    // Logs of numerator and denominator of the resistance ratio
    logic [PROD_W-1:0] xa;
    logic [PROD_W-1:0] xb;
    ln_side_t          lside_in;
    ln_side_t          lside_out;
    logic              la_valid;
    logic [LW-1:0]     la;
    logic [LW-1:0]     lb;
    logic [0:0]        lb_side;

    assign xa = (rside_out.a == '0) ? PROD_W'(1) : rside_out.a;
    assign xb = (rside_out.b == '0) ? PROD_W'(1) : rside_out.b;
    assign lside_in.res   = rside_out.fault ? '0 : (rside_out.sat ? RES_MAX : rquo);
    assign lside_in.fault = rside_out.fault;
    assign lside_in.degen = (rside_out.a == '0) || (rside_out.b == '0) || (beta_reg == '0);
    assign lside_in.neg   = 1'b0;

    tbt_log2 #(
        .FW (L),
        .SW ($bits(ln_side_t))
    ) u_log_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rdiv_valid),
        .x         (xa),
        .side_in   (lside_in),
        .out_valid (la_valid),
        .log2_out  (la),
        .side_out  (lside_out)
    );

    tbt_log2 #(
        .FW (L),
        .SW (1)
    ) u_log_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rdiv_valid),
        .x         (xb),
        .side_in   (1'b0),
        .out_valid (),
        .log2_out  (lb),
        .side_out  (lb_side)
    );

    // Stage 2: log difference and its sign
    logic [LW-1:0] s2_d_reg;
    ln_side_t      s2_side_reg;
    logic          s2_valid_reg;
    // Stage 3: scale by ln2
    logic [PRD_W-1:0] s3_prod_reg;
    ln_side_t         s3_side_reg;
    logic             s3_valid_reg;
    // Stage 4: round and build the beta division numerator
    logic [LW-1:0]     lnmag;
    logic [PRD_W-1:0]  prod_rnd;
    logic [TNUM_W-1:0] s4_num_reg;
    ln_side_t          s4_side_reg;
    logic              s4_valid_reg;
    logic              neg_next;

    assign neg_next = la < lb;
    assign prod_rnd = s3_prod_reg + (PRD_W'(1) << (LN2_W - 1));
    assign lnmag    = LW'(prod_rnd >> LN2_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= la_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_d_reg        <= neg_next ? (lb - la) : (la - lb);
            s2_side_reg     <= '{res: lside_out.res, fault: lside_out.fault,
                                 degen: lside_out.degen, neg: neg_next ^ lb_side[0]};
            s3_prod_reg     <= PRD_W'(s2_d_reg) * PRD_W'(LN2_Q25);
            s3_side_reg     <= s2_side_reg;
            s4_num_reg      <= (TNUM_W'(lnmag) << (INV_FRAC - L))
                               + TNUM_W'(beta_reg >> 1);
            s4_side_reg     <= s3_side_reg;
        end
    end

    // Division by beta
    logic [TNUM_W-1:0] tdiv_num;
    logic [BETA_W-1:0] tdiv_den;
    logic [TNUM_W-1:0] term;
    ln_side_t          tside_out;
    logic              tdiv_valid;

    assign tdiv_num = s4_side_reg.degen ? '0 : s4_num_reg;
    assign tdiv_den = (beta_reg == '0) ? BETA_W'(1) : beta_reg;

    tbt_div #(
        .NW (TNUM_W),
        .DW (BETA_W),
        .QW (TNUM_W),
        .SW ($bits(ln_side_t))
    ) u_beta_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .num       (tdiv_num),
        .den       (tdiv_den),
        .side_in   (s4_side_reg),
        .out_valid (tdiv_valid),
        .quo       (term),
        .side_out  (tside_out)
    );

    // Stage 5: add the 25 degree reciprocal, keep magnitude and sign
    logic [MAG_W-1:0] t0;
    logic [MAG_W-1:0] term_w;
    logic [MAG_W-1:0] mag_next;
    logic             inv_neg_next;
    logic [MAG_W-1:0] s5_mag_reg;
    inv_side_t        s5_side_reg;
    logic             s5_valid_reg;

    assign t0     = MAG_W'(T0INV_Q48);
    assign term_w = MAG_W'(term);

    always_comb
    begin
        inv_neg_next = 1'b0;
        if (!tside_out.neg)
        begin
            mag_next = t0 + term_w;
        end
        else if (term_w > t0)
        begin
            mag_next     = term_w - t0;
            inv_neg_next = 1'b1;
        end
        else
        begin
            mag_next = t0 - term_w;
        end
    end

    // Stage 6: numerator of the reciprocal
    logic [NUM_T_W-1:0] s6_num_reg;
    logic [MAG_W-1:0]   s6_mag_reg;
    inv_side_t          s6_side_reg;
    logic               s6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= tdiv_valid;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_mag_reg  <= mag_next;
            s5_side_reg <= '{res: tside_out.res, fault: tside_out.fault,
                             degen: tside_out.degen, inv_neg: inv_neg_next,
                             inv_zero: (mag_next == '0), sat: 1'b0};
            s6_num_reg  <= NUM_T_W'(HUNDRED_Q48) + NUM_T_W'(s5_mag_reg >> 1);
            s6_mag_reg  <= s5_mag_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // Reciprocal division, saturation decided up front
    localparam int SAT_W = MAG_W + TQ_W;
    logic               tsat;
    logic [NUM_T_W-1:0] qdiv_num;
    logic [MAG_W-1:0]   qdiv_den;
    inv_side_t          qside_in;
    inv_side_t          qside_out;
    logic               qdiv_valid;
    logic [TQ_W-1:0]    qquo;

    assign tsat     = SAT_W'(s6_num_reg) >= (SAT_W'(s6_mag_reg) << TQ_W);
    assign qdiv_num = (s6_side_reg.inv_zero || tsat) ? '0 : s6_num_reg;
    assign qdiv_den = s6_side_reg.inv_zero ? MAG_W'(1) : s6_mag_reg;

    always_comb
    begin
        qside_in     = s6_side_reg;
        qside_in.sat = tsat;
    end

    tbt_div #(
        .NW (NUM_T_W),
        .DW (MAG_W),
        .QW (TQ_W),
        .SW ($bits(inv_side_t))
    ) u_inv_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .num       (qdiv_num),
        .den       (qdiv_den),
        .side_in   (qside_in),
        .out_valid (qdiv_valid),
        .quo       (qquo),
        .side_out  (qside_out)
    );

    // Stage 7: sign, offset to Celsius, saturate, hold for the sink
    logic signed [TQ_W+1:0]  qs;
    logic signed [TQ_W+1:0]  t_wide;
    logic signed [TEMP_W-1:0] temp_next;
    logic [OHMS_W-1:0]        res_out_reg;
    logic [TEMP_W-1:0]        temp_out_reg;
    logic                     fault_out_reg;
    logic                     out_valid_reg;

    assign qs     = signed'({2'b00, qquo});
    assign t_wide = (qside_out.inv_neg ? -qs : qs) - (TQ_W+2)'(KELVIN_OFFSET);

    always_comb
    begin
        if (qside_out.fault)
        begin
            temp_next = '0;
        end
        else if (qside_out.degen)
        begin
            temp_next = -KELVIN_OFFSET;
        end
        else if (qside_out.inv_zero)
        begin
            temp_next = TEMP_MAX;
        end
        else if (qside_out.sat)
        begin
            temp_next = qside_out.inv_neg ? TEMP_MIN : TEMP_MAX;
        end
        else if (t_wide > (TQ_W+2)'(TEMP_MAX))
        begin
            temp_next = TEMP_MAX;
        end
        else if (t_wide < (TQ_W+2)'(TEMP_MIN))
        begin
            temp_next = TEMP_MIN;
        end
        else
        begin
            temp_next = TEMP_W'(t_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= qdiv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_out_reg   <= qside_out.res;
            temp_out_reg  <= temp_next;
            fault_out_reg <= qside_out.fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, temp_out_reg, res_out_reg};
    assign m_tuser  = fault_out_reg;

    `TBT_ASSERT_NOW(a_fault_zeroes, m_tvalid && m_tuser[0],
        (res_out_reg == '0) && (temp_out_reg == '0), "fault beat carries nonzero data")
    `TBT_ASSERT_NOW(a_degen_beta, m_tvalid && !m_tuser[0] && (beta_reg == '0),
        temp_out_reg == -KELVIN_OFFSET, "zero beta did not give the degenerate temperature")
    `TBT_ASSERT_NEXT(a_stall_holds_pipe, m_tvalid && !m_tready,
        !s_tready || m_tready, "pipeline advanced into a held result")

endmodule

// File: hdl/tbt_div.sv
// Pipelined restoring divider, one quotient bit per stage
`include "thermistor_beta_temperature_defines.svh"
module tbt_div #(
    parameter int NW = 37,
    parameter int DW = 16,
    parameter int QW = 20,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);
    // Caller keeps num below den * 2**QW
    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_k;
        logic          valid_in;
        logic [W-1:0]  trial;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in   = W'(num);
            assign den_in   = den;
            assign quo_in   = '0;
            assign side_k   = side_in;
            assign valid_in = in_valid;
        end
        else begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign side_k   = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // Try the shifted divisor, keep the bit when it fits
        assign trial = W'(den_in) << (QW - 1 - k);

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                quo_next = quo_in | (QW'(1) << (QW - 1 - k));
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

    `TBT_ASSERT_NOW(a_rem_below_den, valid_reg[QW-1],
        rem_reg[QW-1] < W'(den_reg[QW-1]), "divider remainder not below divisor")

endmodule

// File: hdl/tbt_log2.sv
// Pipelined fixed-point log2: exponent search, normalise, one squaring per fraction bit
`include "thermistor_beta_temperature_defines.svh"
module tbt_log2 #(
    parameter int FW = 16,
    parameter int SW = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [tbt_pkg::PROD_W-1:0]        x,
    input  logic [SW-1:0]                     side_in,
    output logic                              out_valid,
    output logic [tbt_pkg::EXP_W+FW-1:0]      log2_out,
    output logic [SW-1:0]                     side_out
);
    import tbt_pkg::*;

    // Stage A: find the leading one
    logic [EXP_W-1:0]  n_next;
    logic [EXP_W-1:0]  a_n_reg;
    logic [PROD_W-1:0] a_x_reg;
    logic [SW-1:0]     a_side_reg;
    logic              a_valid_reg;

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (x[i])
            begin
                n_next = EXP_W'(i);
            end
        end
    end

    // Stage B: normalise to Q1.31
    logic [31:0]      m_next;
    logic [31:0]      b_m_reg;
    logic [EXP_W-1:0] b_n_reg;
    logic [SW-1:0]    b_side_reg;
    logic             b_valid_reg;

    always_comb
    begin
        if (a_n_reg <= EXP_W'(31))
        begin
            m_next = 32'(a_x_reg << (EXP_W'(31) - a_n_reg));
        end
        else
        begin
            m_next = 32'(a_x_reg >> (a_n_reg - EXP_W'(31)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n_reg    <= n_next;
            a_x_reg    <= x;
            a_side_reg <= side_in;
            b_m_reg    <= m_next;
            b_n_reg    <= a_n_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // Squaring stages, one fraction bit each
    logic [31:0]      m_reg     [FW];
    logic [FW-1:0]    frac_reg  [FW];
    logic [EXP_W-1:0] n_reg     [FW];
    logic [SW-1:0]    side_reg  [FW];
    logic [FW-1:0]    valid_reg;

    for (genvar k = 0; k < FW; k++) begin : g_sq
        logic [31:0]      m_in;
        logic [FW-1:0]    frac_in;
        logic [EXP_W-1:0] n_in;
        logic [SW-1:0]    side_k;
        logic             valid_in;
        logic [63:0]      sq;
        logic [32:0]      sq_q;
        logic [31:0]      m_sq_next;
        logic [FW-1:0]    frac_next;

        if (k == 0) begin : g_first
            assign m_in     = b_m_reg;
            assign frac_in  = '0;
            assign n_in     = b_n_reg;
            assign side_k   = b_side_reg;
            assign valid_in = b_valid_reg;
        end
        else begin : g_rest
            assign m_in     = m_reg[k-1];
            assign frac_in  = frac_reg[k-1];
            assign n_in     = n_reg[k-1];
            assign side_k   = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        assign sq        = 64'(m_in) * 64'(m_in);
        assign sq_q      = sq[63:31];
        assign m_sq_next = sq_q[32] ? sq_q[32:1] : sq_q[31:0];
        assign frac_next = {frac_in[FW-2:0], sq_q[32]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]    <= m_sq_next;
                frac_reg[k] <= frac_next;
                n_reg[k]    <= n_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = valid_reg[FW-1];
    assign log2_out  = {n_reg[FW-1], frac_reg[FW-1]};
    assign side_out  = side_reg[FW-1];

    `TBT_ASSERT_NOW(a_norm_msb, b_valid_reg, b_m_reg[31], "mantissa not normalised")
    `TBT_ASSERT_NOW(a_sq_msb, valid_reg[FW-1], m_reg[FW-1][31],
        "squared mantissa lost its leading one")

endmodule
